@@ sv/line_sensor_position_tracker_core_defines.svh @@
// assertion macros for the line sensor tracker core
// used by the top level only
`ifndef LINE_SENSOR_POSITION_TRACKER_CORE_DEFINES_SVH
`define LINE_SENSOR_POSITION_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTH
`define LSPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSPT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSPT_ASSERT(label, clk, rst_n, prop, msg)
`define LSPT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ sv/lspt_pkg.sv @@
// shared constants and types for the line sensor tracker
// no dependencies
`timescale 1ns / 1ps
package lspt_pkg;
  localparam int NUM_SENSORS = 7;
  localparam int AVG_WINDOW  = 3;
  localparam int SW          = 12;
  localparam int IW          = 3;
  localparam int PW          = 11;
  localparam int CW          = 16;
  localparam int SUMW        = 14;
  localparam logic [CW-1:0] MAXV16 = 16'hFFFF;
  localparam logic [IW-1:0] WIDE_LIMIT = 3'd5;
  localparam logic [2:0] REG_THR_LO  = 3'd0;
  localparam logic [2:0] REG_THR_HI  = 3'd1;
  localparam logic [2:0] REG_FREEZE  = 3'd2;
  localparam logic [2:0] REG_CONFIRM = 3'd3;
  localparam logic [2:0] REG_REARM   = 3'd4;
  typedef logic [SW-1:0] sample_t;
endpackage

@@ sv/line_sensor_position_tracker_core.sv @@
// line sensor tracker core: averaging, black scan, junction and position logic
// depends on lspt_pkg and line_sensor_position_tracker_core_defines.svh
`timescale 1ns / 1ps
// usage:
// in_ channel takes one frame beat of seven 12-bit readings and a racing flag.
// out_ channel gives one result beat per frame; cfg_ channel writes registers
// (index 0..4) and is taken only while no frame is in work and no result waits.
// a frame runs through a small sequencer: the accepting edge loads the history,
// the scan state averages and judges one sensor at a time through one shared adder,
// reciprocal multiply and comparator, the run choice state weighs the runs one at
// a time through one shared distance unit, a restoring divider computes the
// centroid one quotient bit at a time, and an update state registers the result.
// in_ready is low from accept until the result beat has been taken, so a new
// frame is not accepted before the result of the last one has left.
// the result register holds while out_ready is low and stalls the input.
// reset restores register defaults, clears the averaging history (held in
// flip-flops, no clearing pass) and sets the held position to index three.
module line_sensor_position_tracker_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  lspt_pkg::sample_t in_sensor_0,
  input  lspt_pkg::sample_t in_sensor_1,
  input  lspt_pkg::sample_t in_sensor_2,
  input  lspt_pkg::sample_t in_sensor_3,
  input  lspt_pkg::sample_t in_sensor_4,
  input  lspt_pkg::sample_t in_sensor_5,
  input  lspt_pkg::sample_t in_sensor_6,
  input  logic in_racing,
  output logic out_valid,
  input  logic out_ready,
  output logic out_found,
  output logic [2:0] out_first_index,
  output logic [10:0] out_track_pos,
  output logic out_at_cross,
  output logic [2:0] out_dark_count,
  output logic [2:0] out_span,
  output logic [2:0] out_seg_count,
  output logic [10:0] out_mean_pos,
  output logic [15:0] out_freeze_count,
  output logic [15:0] out_pass_count,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [47:0] cfg_data
);
  import lspt_pkg::*;
`include "line_sensor_position_tracker_core_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RUNS = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_r;
  logic [47:0] thr_lo_r;
  logic [35:0] thr_hi_r;
  logic [CW-1:0] freeze_max_r, confirm_r, rearm_r;

  sample_t hist_r [NUM_SENSORS][AVG_WINDOW];
  logic [1:0] slot_r;
  logic racing_r;

  logic [IW-1:0] held_idx_r;
  logic [PW-1:0] held_pos_r;
  logic [CW-1:0] frozen_r, passes_r, on_r, off_r;
  logic counted_r;

  logic [IW-1:0] k_r;
  logic [IW:0] count_r;
  logic [IW-1:0] first_r, last_r;
  logic [IW:0] runs_r;
  logic [4:0] idx_sum_r;
  logic prev_r;
  logic [IW-1:0] rs_r [NUM_SENSORS];
  logic [IW-1:0] re_r [NUM_SENSORS];
  logic [PW-1:0] best_r, best_err_r;
  logic [12:0] rem_r;
  logic [12:0] quo_r;
  logic [3:0] dstep_r;

  logic out_valid_r;
  logic o_found_r, o_junc_r;
  logic [IW-1:0] o_idx_r, o_cnt_r, o_span_r, o_runs_r;
  logic [PW-1:0] o_pos_r, o_raw_r;
  logic [CW-1:0] o_frz_r, o_pass_r;

  // shared sensor unit: sum of the window, divide by three, compare with threshold
  logic [SUMW-1:0] sum_w;
  logic [SW-1:0] avg_w;
  logic [SW-1:0] thr_w;
  logic black_w;
  logic [IW-1:0] cur_w;
  always_comb begin
    sum_w = {2'b0, hist_r[k_r][0]} + {2'b0, hist_r[k_r][1]} + {2'b0, hist_r[k_r][2]};
    avg_w = SW'((32'(sum_w) * 32'd21846) >> 16);
    unique case (k_r)
      3'd0: thr_w = thr_lo_r[11:0];
      3'd1: thr_w = thr_lo_r[23:12];
      3'd2: thr_w = thr_lo_r[35:24];
      3'd3: thr_w = thr_lo_r[47:36];
      3'd4: thr_w = thr_hi_r[11:0];
      3'd5: thr_w = thr_hi_r[23:12];
      3'd6: thr_w = thr_hi_r[35:24];
      default: thr_w = '0;
    endcase
    black_w = (avg_w <= thr_w);
    cur_w = k_r;
  end

  // shared distance unit for run choice
  logic [PW-1:0] cen_w, err_w;
  always_comb begin
    cen_w = PW'({4'b0, rs_r[k_r]} + {4'b0, re_r[k_r]}) << 7;
    err_w = (cen_w > held_pos_r) ? cen_w - held_pos_r : held_pos_r - cen_w;
  end

  logic [12:0] rem_sh_w;
  logic [4:0] div_w;
  always_comb begin
    div_w = {1'b0, count_r};
    rem_sh_w = {rem_r[11:0], quo_r[12]};
  end

  logic degenerate_w, junc_w, frz_w;
  logic [IW:0] span_w;
  always_comb begin
    degenerate_w = (count_r == '0) || (count_r >= 4'(NUM_SENSORS));
    span_w = (count_r != '0) ? {1'b0, last_r} - {1'b0, first_r} + 4'd1 : '0;
    junc_w = (count_r >= 4'(NUM_SENSORS - 1))
          || (span_w >= {1'b0, WIDE_LIMIT} && runs_r == 4'd1)
          || (count_r >= {1'b0, WIDE_LIMIT} && runs_r >= 4'd2);
    frz_w = junc_w && (frozen_r < freeze_max_r);
  end

  // streak counters and pass decision
  logic [CW-1:0] on_inc_w, off_inc_w;
  logic pass_hit_w;
  always_comb begin
    on_inc_w = (on_r < MAXV16) ? on_r + 16'd1 : on_r;
    off_inc_w = (off_r < MAXV16) ? off_r + 16'd1 : off_r;
    pass_hit_w = racing_r && !degenerate_w && junc_w && !counted_r
              && (on_inc_w >= confirm_r);
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thr_lo_r <= 48'd56294995342131;
      thr_hi_r <= 36'd13743895347;
      freeze_max_r <= 16'd200;
      confirm_r <= 16'd10;
      rearm_r <= 16'd100;
      for (int i = 0; i < NUM_SENSORS; i++)
        for (int j = 0; j < AVG_WINDOW; j++) hist_r[i][j] <= '0;
      slot_r <= '0;
      held_idx_r <= IW'(NUM_SENSORS / 2);
      held_pos_r <= PW'((NUM_SENSORS / 2) * 256);
      frozen_r <= '0;
      passes_r <= '0;
      on_r <= '0;
      off_r <= '0;
      counted_r <= 1'b0;
      out_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_THR_LO:  thr_lo_r <= cfg_data;
          REG_THR_HI:  thr_hi_r <= cfg_data[35:0];
          REG_FREEZE:  freeze_max_r <= cfg_data[15:0];
          REG_CONFIRM: confirm_r <= cfg_data[15:0];
          REG_REARM:   rearm_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            hist_r[0][slot_r] <= in_sensor_0;
            hist_r[1][slot_r] <= in_sensor_1;
            hist_r[2][slot_r] <= in_sensor_2;
            hist_r[3][slot_r] <= in_sensor_3;
            hist_r[4][slot_r] <= in_sensor_4;
            hist_r[5][slot_r] <= in_sensor_5;
            hist_r[6][slot_r] <= in_sensor_6;
            slot_r <= (slot_r == 2'(AVG_WINDOW - 1)) ? '0 : slot_r + 2'd1;
            racing_r <= in_racing;
            k_r <= '0;
            count_r <= '0;
            first_r <= '0;
            last_r <= '0;
            runs_r <= '0;
            idx_sum_r <= '0;
            prev_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (black_w) begin
            if (count_r == '0) first_r <= cur_w;
            last_r <= cur_w;
            count_r <= count_r + 4'd1;
            idx_sum_r <= idx_sum_r + {2'b0, cur_w};
            if (!prev_r) begin
              rs_r[runs_r[IW-1:0]] <= cur_w;
              re_r[runs_r[IW-1:0]] <= cur_w;
              runs_r <= runs_r + 4'd1;
            end else begin
              re_r[runs_r[IW-1:0] - 3'd1] <= cur_w;
            end
          end
          prev_r <= black_w;
          if (k_r == IW'(NUM_SENSORS - 1)) begin
            k_r <= '0;
            state_r <= S_RUNS;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_RUNS: begin
          if (k_r == '0 || err_w < best_err_r) begin
            best_r <= cen_w;
            best_err_r <= err_w;
          end
          if ({1'b0, k_r} + 4'd1 >= runs_r) begin
            quo_r <= {idx_sum_r, 8'b0};
            rem_r <= '0;
            dstep_r <= '0;
            state_r <= S_DIV;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_DIV: begin
          if (rem_sh_w >= {8'b0, div_w}) begin
            rem_r <= rem_sh_w - {8'b0, div_w};
            quo_r <= {quo_r[11:0], 1'b1};
          end else begin
            rem_r <= rem_sh_w;
            quo_r <= {quo_r[11:0], 1'b0};
          end
          dstep_r <= dstep_r + 4'd1;
          if (dstep_r == 4'd12) state_r <= S_UPD;
        end
        S_UPD: begin
          o_cnt_r <= count_r[IW-1:0];
          o_span_r <= span_w[IW-1:0];
          o_runs_r <= runs_r[IW-1:0];
          if (racing_r) begin
            if (!degenerate_w && junc_w) begin
              off_r <= '0;
              on_r <= on_inc_w;
              if (pass_hit_w) begin
                if (passes_r < MAXV16) passes_r <= passes_r + 16'd1;
                counted_r <= 1'b1;
              end
            end else begin
              on_r <= '0;
              off_r <= off_inc_w;
              if (counted_r && (off_inc_w >= rearm_r)) counted_r <= 1'b0;
            end
          end
          o_pass_r <= (pass_hit_w && passes_r < MAXV16) ? passes_r + 16'd1 : passes_r;
          if (degenerate_w) begin
            frozen_r <= '0;
            o_found_r <= 1'b0;
            o_junc_r <= 1'b0;
            o_frz_r <= '0;
            o_idx_r <= held_idx_r;
            o_pos_r <= held_pos_r;
            o_raw_r <= held_pos_r;
          end else begin
            o_found_r <= 1'b1;
            o_raw_r <= quo_r[PW-1:0];
            if (frz_w) begin
              frozen_r <= frozen_r + 16'd1;
              o_frz_r <= frozen_r + 16'd1;
              o_junc_r <= 1'b1;
              o_idx_r <= held_idx_r;
              o_pos_r <= held_pos_r;
            end else begin
              frozen_r <= '0;
              o_frz_r <= '0;
              o_junc_r <= 1'b0;
              o_idx_r <= first_r;
              held_idx_r <= first_r;
              if (runs_r >= 4'd2) begin
                o_pos_r <= best_r;
                held_pos_r <= best_r;
              end else begin
                o_pos_r <= quo_r[PW-1:0];
                held_pos_r <= quo_r[PW-1:0];
              end
            end
          end
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_found = o_found_r;
  assign out_first_index = o_idx_r;
  assign out_track_pos = o_pos_r;
  assign out_at_cross = o_junc_r;
  assign out_dark_count = o_cnt_r;
  assign out_span = o_span_r;
  assign out_seg_count = o_runs_r;
  assign out_mean_pos = o_raw_r;
  assign out_freeze_count = o_frz_r;
  assign out_pass_count = o_pass_r;

  `LSPT_ASSERT(a_busy_not_ready, clk, rst_n, (state_r != S_IDLE) |-> !in_ready, "ready while busy")
  `LSPT_ASSERT(a_result_blocks, clk, rst_n, out_valid_r |-> !in_ready, "ready with result pending")
  `LSPT_ASSERT(a_junc_found, clk, rst_n, (out_valid_r && o_junc_r) |-> (o_found_r && o_frz_r != '0), "junction without found")
  `LSPT_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset not idle")
endmodule
